FILE: hw/rtl/y2g_pkg.sv
// Package: coefficients and arithmetic helpers for the YUY2 to GRBI16 converter.
package y2g_pkg;

  // Width of the product terms and of the scaled terms
  localparam int unsigned PROD_W = 18;
  localparam int unsigned TERM_W = 16;

  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [TERM_W-1:0] term_t;

  // BT.601 integer coefficients
  localparam prod_t C_TY   = 18'sd298;
  localparam prod_t C_RV   = 18'sd409;
  localparam prod_t C_BU   = 18'sd516;
  localparam prod_t C_GU   = 18'sd100;
  localparam prod_t C_GV   = 18'sd208;
  localparam prod_t C_RND  = 18'sd128;
  localparam prod_t Y_OFS  = 18'sd16;
  localparam prod_t C_OFS  = 18'sd128;

  // Channel limits
  localparam logic [4:0] MAX5 = 5'h1f;
  localparam logic [5:0] MAX6 = 6'h3f;

  // Divide by 8, truncating toward zero
  function automatic term_t div8(input prod_t x);
    prod_t t;
    t = x + (x[PROD_W-1] ? 18'sd7 : 18'sd0);
    div8 = TERM_W'(t >>> 3);
  endfunction

  // Floor shift by 8 and clamp to 0..31
  function automatic logic [4:0] clamp5(input term_t s);
    logic [6:0] v;
    v = s[14:8];
    if (s[TERM_W-1]) clamp5 = 5'd0;
    else if (v > 7'(MAX5)) clamp5 = MAX5;
    else clamp5 = v[4:0];
  endfunction

  // Floor shift by 7 and clamp to 0..63
  function automatic logic [5:0] clamp6(input term_t s);
    logic [7:0] v;
    v = s[14:7];
    if (s[TERM_W-1]) clamp6 = 6'd0;
    else if (v > 8'(MAX6)) clamp6 = MAX6;
    else clamp6 = v[5:0];
  endfunction

endpackage

FILE: hw/rtl/yuy2_to_grbi16_converter.sv
// Top level: four-stage pipelined YUY2 macropixel to two GRBI16 pixels converter.
//
//   channel | direction | handshake             | payload
//   in_     | input     | in_valid / in_ready   | luma_a, chroma_blue, luma_b, chroma_red, last_pair
//   out_    | output    | out_valid / out_ready | pixel_a, pixel_b, last_pair_out
//
// One beat per cycle sustained while out_ready is high.
// Stages: coefficient multiply, divide-by-8 and chroma sum, channel sums, clamp and pack.
// Reset clears the stage valid bits only; data registers are not reset.
// A stall stops only the stages that hold valid data behind it, so bubbles are squeezed out.
module yuy2_to_grbi16_converter
  import y2g_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_luma_a,
  input  logic [7:0]  in_chroma_blue,
  input  logic [7:0]  in_luma_b,
  input  logic [7:0]  in_chroma_red,
  input  logic        in_last_pair,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_pixel_a,
  output logic [15:0] out_pixel_b,
  output logic        out_last_pair_out
);

  // Stage valid bits
  logic v1_r, v2_r, v3_r, v4_r;
  logic v1_nxt, v2_nxt, v3_nxt, v4_nxt;
  logic en1, en2, en3, en4;

  // Stage 1: products
  prod_t pa_r, pb_r, prv_r, pbu_r, pgu_r, pgv_r;
  prod_t pa_nxt, pb_nxt, prv_nxt, pbu_nxt, pgu_nxt, pgv_nxt;
  logic  l1_r;

  // Stage 2: scaled terms
  term_t tya_r, tyb_r, rv_r, bu_r, guv_r;
  term_t guv_nxt;
  logic  l2_r;

  // Stage 3: channel sums
  term_t ra_r, ba_r, ga_r, rb_r, bb_r, gb_r;
  logic  l3_r;

  // Stage 4: output register
  logic [15:0] pxa_r, pxb_r;
  logic        l4_r;

  // Advance a stage when it is empty or the next one advances
  assign en4 = !v4_r || out_ready;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign in_ready = en1;

  assign v1_nxt = en1 ? in_valid : v1_r;
  assign v2_nxt = en2 ? v1_r : v2_r;
  assign v3_nxt = en3 ? v2_r : v3_r;
  assign v4_nxt = en4 ? v3_r : v4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
      v4_r <= v4_nxt;
    end
  end

  // Multiply offset samples by their coefficients
  always_comb begin
    pa_nxt  = (PROD_W'({1'b0, in_luma_a}) - Y_OFS) * C_TY + C_RND;
    pb_nxt  = (PROD_W'({1'b0, in_luma_b}) - Y_OFS) * C_TY + C_RND;
    prv_nxt = (PROD_W'({1'b0, in_chroma_red}) - C_OFS) * C_RV;
    pbu_nxt = (PROD_W'({1'b0, in_chroma_blue}) - C_OFS) * C_BU;
    pgu_nxt = (PROD_W'({1'b0, in_chroma_blue}) - C_OFS) * C_GU;
    pgv_nxt = (PROD_W'({1'b0, in_chroma_red}) - C_OFS) * C_GV;
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      pa_r  <= pa_nxt;
      pb_r  <= pb_nxt;
      prv_r <= prv_nxt;
      pbu_r <= pbu_nxt;
      pgu_r <= pgu_nxt;
      pgv_r <= pgv_nxt;
      l1_r  <= in_last_pair;
    end
  end

  // Scale terms by 1/8 and merge the green chroma terms
  assign guv_nxt = div8(pgu_r) + div8(pgv_r);

  always_ff @(posedge clk) begin
    if (en2) begin
      tya_r <= div8(pa_r);
      tyb_r <= div8(pb_r);
      rv_r  <= div8(prv_r);
      bu_r  <= div8(pbu_r);
      guv_r <= guv_nxt;
      l2_r  <= l1_r;
    end
  end

  // Form channel sums for both pixels
  always_ff @(posedge clk) begin
    if (en3) begin
      ra_r <= tya_r + rv_r;
      ba_r <= tya_r + bu_r;
      ga_r <= tya_r - guv_r;
      rb_r <= tyb_r + rv_r;
      bb_r <= tyb_r + bu_r;
      gb_r <= tyb_r - guv_r;
      l3_r <= l2_r;
    end
  end

  // Clamp and pack green, red, blue
  always_ff @(posedge clk) begin
    if (en4) begin
      pxa_r <= {clamp5(ga_r), clamp5(ra_r), clamp6(ba_r)};
      pxb_r <= {clamp5(gb_r), clamp5(rb_r), clamp6(bb_r)};
      l4_r  <= l3_r;
    end
  end

  assign out_valid         = v4_r;
  assign out_pixel_a       = pxa_r;
  assign out_pixel_b       = pxb_r;
  assign out_last_pair_out = l4_r;

  // A full, stalled pipeline takes no beat
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && v2_r && v3_r && v4_r && !out_ready) |-> !in_ready)
    else $error("beat accepted into a full stalled pipeline");

  // Occupancy tracks accepted and delivered beats
  a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (3'($countones({v1_r, v2_r, v3_r, v4_r})) ==
      3'($countones($past({v1_r, v2_r, v3_r, v4_r})))
      + 3'($past(in_valid && in_ready)) - 3'($past(out_valid && out_ready))))
    else $error("pipeline lost or duplicated a beat");

  // Data in stage 3 reaches the output when the output frees up
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && (!out_valid || out_ready)) |=> out_valid)
    else $error("stage 3 beat did not advance to the output");

endmodule
